/* rtl/core/acctilt_pkg.sv */
`timescale 1ns / 1ps
package acctilt_pkg;

  // Angle accumulator: 2^32 units per turn, rounded-to-nearest atan(2^-i)
  localparam int AccBits = 34;
  localparam int Guard   = 26;

  typedef logic [31:0] atan_word_t;

  function automatic atan_word_t atan_const(input int i);
    atan_word_t t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
      27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
      30: t = 32'd1;         default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/accel_tilt_angles_top.sv */
`timescale 1ns / 1ps
// Stages: magnitudes, squares and sums, square roots, CORDICs, output register.
// Throughput: one sample per cycle; every stage of the square root and CORDIC
// pipelines is registered and all advance together, stalled only by m_tready.
// Reset (rst, synchronous, active high) clears valid bits and sets
// one_g to 16384.
module accel_tilt_angles_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pitch_angle, roll_angle, tilt_angle
  output logic        m_tuser    // tilt_saturated
);
  localparam int SB = SAMPLE_BITS;
  localparam int MB = (SB + 1 > 16) ? SB + 1 : 16;  // root / magnitude width
  localparam int RB = 2 * MB;         // radicand width, even
  localparam int AB = acctilt_pkg::AccBits;
  localparam int Sh = 32 - ANGLE_BITS;

  logic [14:0] one_g;
  always_ff @(posedge clk) begin
    if (rst) begin
      one_g <= 15'd16384;
    end else if (cfg_we) begin
      one_g <= cfg_wdata;
    end
  end

  // advance whenever output slot is free or being taken
  logic en;
  logic out_v;
  assign en       = !out_v || m_tready;
  assign s_tready = en;

  // stage 1: sign-extend, magnitudes
  logic             v1;
  logic [MB-1:0]    mx1, my1, mz1;
  logic             nx1, ny1, nz1;
  logic [15:0]      g1;
  logic signed [SB-1:0] ax, ay, az;
  assign ax = SB'(s_tdata[15:0]);
  assign ay = SB'(s_tdata[31:16]);
  assign az = SB'(s_tdata[47:32]);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx1 <= ax[SB-1] ? -(MB'(ax)) : MB'(ax);
      my1 <= ay[SB-1] ? -(MB'(ay)) : MB'(ay);
      mz1 <= az[SB-1] ? -(MB'(az)) : MB'(az);
      nx1 <= ax[SB-1]; ny1 <= ay[SB-1]; nz1 <= az[SB-1];
      g1  <= {1'b0, one_g};
    end
  end

  // stage 2: squares and sums
  logic          v2;
  logic [RB-1:0] rp2, rr2, rt2;
  logic [MB-1:0] mx2, my2, mz2;
  logic          nx2, ny2, nz2, sat2;
  logic [RB-1:0] sx, sy, sz, gg;
  assign sx = RB'(mx1 * mx1);
  assign sy = RB'(my1 * my1);
  assign sz = RB'(mz1 * mz1);
  assign gg = RB'(g1 * g1);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rp2  <= sy + sz;
      rr2  <= sx + sz;
      sat2 <= MB'(g1) <= mz1;
      rt2  <= (MB'(g1) <= mz1) ? '0 : gg - sz;
      mx2 <= mx1; my2 <= my1; mz2 <= mz1;
      nx2 <= nx1; ny2 <= ny1; nz2 <= nz1;
    end
  end

  // square roots; side band carries magnitudes and signs
  localparam int SdB = 3 * MB + 4;
  logic          vq;
  logic [MB-1:0] qp, qr, qt;
  logic [SdB-1:0] sdq, sd2;
  assign sd2 = {sat2, nz2, ny2, nx2, mz2, my2, mx2};
  acctilt_isqrt #(.InBits(RB), .SideBits(SdB)) u_sq_p (
    .clk, .rst, .en, .in_valid(v2), .in_rad(rp2), .in_side(sd2),
    .out_valid(vq), .out_root(qp), .out_side(sdq));
  acctilt_isqrt #(.InBits(RB), .SideBits(1)) u_sq_r (
    .clk, .rst, .en, .in_valid(v2), .in_rad(rr2), .in_side(1'b0),
    .out_valid(), .out_root(qr), .out_side());
  acctilt_isqrt #(.InBits(RB), .SideBits(1)) u_sq_t (
    .clk, .rst, .en, .in_valid(v2), .in_rad(rt2), .in_side(1'b0),
    .out_valid(), .out_root(qt), .out_side());

  logic [MB-1:0] qmx, qmy, qmz;
  logic          qnx, qny, qnz, qsat;
  assign {qsat, qnz, qny, qnx, qmz, qmy, qmx} = sdq;

  // CORDICs
  logic                 vc;
  logic signed [AB-1:0] zp, zr, zt;
  logic [3:0]           sdc;
  acctilt_cordic #(.MagBits(MB), .Stages(CORDIC_STAGES), .SideBits(4)) u_co_p (
    .clk, .rst, .en, .in_valid(vq), .in_x(qp), .in_y(qmx),
    .in_side({qsat, qnz, qny, qnx}), .out_valid(vc), .out_z(zp), .out_side(sdc));
  acctilt_cordic #(.MagBits(MB), .Stages(CORDIC_STAGES), .SideBits(1)) u_co_r (
    .clk, .rst, .en, .in_valid(vq), .in_x(qr), .in_y(qmy),
    .in_side(1'b0), .out_valid(), .out_z(zr), .out_side());
  acctilt_cordic #(.MagBits(MB), .Stages(CORDIC_STAGES), .SideBits(1)) u_co_t (
    .clk, .rst, .en, .in_valid(vq), .in_x(qmz), .in_y(qt),
    .in_side(1'b0), .out_valid(), .out_z(zt), .out_side());

  // final: sign, round, clamp
  logic csat, cnz, cny, cnx;
  assign {csat, cnz, cny, cnx} = sdc;
  logic signed [AB-1:0] fp, fr, ft;
  logic signed [AB-1:0] ap, ar, at;
  localparam logic signed [AB-1:0] Half = (ANGLE_BITS < 32) ? AB'(1) << (31 - ANGLE_BITS) : '0;
  localparam logic signed [AB-1:0] Qt = AB'(1) << (ANGLE_BITS - 2);
  localparam logic signed [AB-1:0] Ht = AB'(1) << (ANGLE_BITS - 1);
  assign fp = cnx ? -zp : zp;
  assign fr = cny ? -zr : zr;
  assign ft = cnz ? (AB'(1) << 31) - zt : zt;
  assign ap = (fp + Half) >>> Sh;
  assign ar = (fr + Half) >>> Sh;
  assign at = (ft + Half) >>> Sh;

  logic [15:0] op, orr, ot;
  logic        os;
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      op  <= 16'((ap < -Qt) ? -Qt : (ap > Qt) ? Qt : ap);
      orr <= 16'((ar < -Qt) ? -Qt : (ar > Qt) ? Qt : ar);
      if (csat) ot <= cnz ? 16'(Ht) : 16'd0;
      else ot <= 16'((at < 0) ? '0 : (at > Ht) ? Ht : at);
      os  <= csat;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {ot, orr, op};
  assign m_tuser  = os;
endmodule

/* rtl/core/acctilt_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root: one result bit per stage, each stage registered.
module acctilt_isqrt #(
  parameter int InBits = 32,
  parameter int SideBits = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [InBits-1:0]     in_rad,
  input  logic [SideBits-1:0]   in_side,
  output logic                  out_valid,
  output logic [InBits/2-1:0]   out_root,
  output logic [SideBits-1:0]   out_side
);
  localparam int RBits = InBits / 2;

  logic [RBits:0]       vld;
  logic [InBits-1:0]    rem [RBits+1];
  logic [RBits-1:0]     root [RBits+1];
  logic [SideBits-1:0]  side [RBits+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rad;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < RBits; k++) begin : g_st
    localparam int Sh = 2 * (RBits - 1 - k);
    logic [InBits+1:0] trial;
    logic [InBits+1:0] cur;
    logic              take;
    // trial subtract of (4r+1) at this bit pair
    assign trial = {({2'b0, root[k]} << 2) | (InBits+2)'(1)} << Sh;
    assign cur   = {2'b0, rem[k]};
    assign take  = cur >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? InBits'(cur - trial) : rem[k];
        root[k+1] <= {root[k][RBits-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[RBits];
  assign out_root  = root[RBits];
  assign out_side  = side[RBits];
endmodule

/* rtl/core/acctilt_cordic.sv */
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC, one rotation per registered stage.
// Input in_x >= 0, in_y >= 0 magnitudes; result angle in 2^32 units per turn.
module acctilt_cordic #(
  parameter int MagBits = 16,
  parameter int Stages = 16,
  parameter int SideBits = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [MagBits-1:0]                  in_x,
  input  logic [MagBits-1:0]                  in_y,
  input  logic [SideBits-1:0]                 in_side,
  output logic                                out_valid,
  output logic signed [acctilt_pkg::AccBits-1:0] out_z,
  output logic [SideBits-1:0]                 out_side
);
  localparam int WBits = MagBits + acctilt_pkg::Guard + 3;
  localparam int AB = acctilt_pkg::AccBits;

  logic [Stages:0]         vld;
  logic signed [WBits-1:0] xs [Stages+1];
  logic signed [WBits-1:0] ys [Stages+1];
  logic signed [AB-1:0]    zs [Stages+1];
  logic                    zz [Stages+1];
  logic [SideBits-1:0]     side [Stages+1];

  assign vld[0]  = in_valid;
  assign xs[0]   = WBits'({in_x, {acctilt_pkg::Guard{1'b0}}});
  assign ys[0]   = WBits'({in_y, {acctilt_pkg::Guard{1'b0}}});
  assign zs[0]   = '0;
  assign zz[0]   = (in_x == '0) && (in_y == '0);
  assign side[0] = in_side;

  for (genvar i = 0; i < Stages; i++) begin : g_st
    localparam int Sh = (i < 32) ? i : 31;
    localparam logic signed [AB-1:0] Ang =
      (i < 32) ? AB'(acctilt_pkg::atan_const(i)) : '0;
    logic signed [WBits-1:0] xsh, ysh;
    assign xsh = xs[i] >>> Sh;
    assign ysh = ys[i] >>> Sh;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    // rotate toward y = 0
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][WBits-1]) begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + Ang;
        end else begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - Ang;
        end
        zz[i+1]   <= zz[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign out_z     = zz[Stages] ? '0 : zs[Stages];
  assign out_side  = side[Stages];
endmodule
